### hdl/usvg_pkg.sv
// UV sphere vertex generator: shared types, constants and helper functions.
// Used by usvg_div, usvg_cordic and uv_sphere_vertex_generator_unit.
package usvg_pkg;

  localparam int CordicStages = 16;
  localparam int MaxSegments  = 255;
  localparam int IdxW         = 8;
  localparam int SegW         = 8;
  localparam int RadW         = 16;
  localparam int TexW         = 17;
  localparam int NormW        = 16;
  localparam int PosW         = 17;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 16;
  localparam int XW           = 34;
  localparam int ZW           = 33;
  localparam int KW           = 5;

  localparam logic [31:0]          PiQ30   = 32'hC90F_DAA2;
  localparam logic signed [XW-1:0] GainQ30 = 34'sh0_26DD_3B6A;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_SEGS = 2'd0,
    CFG_LAT_SEGS  = 2'd1,
    CFG_RADIUS    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SegW-1:0] rem;
    logic [TexW-1:0] lo;
    logic [TexW-1:0] quo;
    logic [SegW-1:0] dvs;
  } div_lane_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg_c;
    logic                 neg_s;
    logic [TexW-1:0]      tag;
  } cordic_stage_t;

  function automatic div_lane_t div_step(input div_lane_t a);
    div_lane_t    r;
    logic [SegW:0] t;
    r = a;
    t = {a.rem, a.lo[TexW-1]};
    r.lo = {a.lo[TexW-2:0], 1'b0};
    if (t >= {1'b0, a.dvs}) begin
      r.rem = SegW'(t - {1'b0, a.dvs});
      r.quo = {a.quo[TexW-2:0], 1'b1};
    end else begin
      r.rem = t[SegW-1:0];
      r.quo = {a.quo[TexW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic signed [ZW-1:0] atan_q30(input logic [KW-1:0] k);
    logic signed [ZW-1:0] a;
    case (k)
      5'd0:    a = 33'sd843314857;
      5'd1:    a = 33'sd497837829;
      5'd2:    a = 33'sd263043837;
      5'd3:    a = 33'sd133525159;
      5'd4:    a = 33'sd67021687;
      5'd5:    a = 33'sd33543516;
      5'd6:    a = 33'sd16775851;
      5'd7:    a = 33'sd8388437;
      5'd8:    a = 33'sd4194283;
      5'd9:    a = 33'sd2097149;
      5'd10:   a = 33'sd1048576;
      5'd11:   a = 33'sd524288;
      5'd12:   a = 33'sd262144;
      5'd13:   a = 33'sd131072;
      5'd14:   a = 33'sd65536;
      5'd15:   a = 33'sd32768;
      5'd16:   a = 33'sd16384;
      5'd17:   a = 33'sd8192;
      5'd18:   a = 33'sd4096;
      5'd19:   a = 33'sd2048;
      5'd20:   a = 33'sd1024;
      5'd21:   a = 33'sd512;
      5'd22:   a = 33'sd256;
      5'd23:   a = 33'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### hdl/usvg_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Depends on usvg_pkg (div_lane_t, div_step).
module usvg_div import usvg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  div_lane_t       lane_u_i,
  input  div_lane_t       lane_v_i,
  output logic            vld_o,
  output logic [TexW-1:0] quo_u_o,
  output logic [TexW-1:0] quo_v_o
);

  localparam int Steps = TexW;

  logic [Steps:0] vld_q;
  div_lane_t      u_q [Steps+1];
  div_lane_t      v_q [Steps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Steps-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    u_q[0] <= lane_u_i;
    v_q[0] <= lane_v_i;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    always_ff @(posedge clk_i) begin
      u_q[s+1] <= div_step(u_q[s]);
      v_q[s+1] <= div_step(v_q[s]);
    end
  end

  assign vld_o   = vld_q[Steps];
  assign quo_u_o = u_q[Steps].quo;
  assign quo_v_o = v_q[Steps].quo;

endmodule

### hdl/usvg_cordic.sv
// Pipelined rotation-mode CORDIC: quadrant fold, phase scaling, one stage per
// iteration, Q1.14 rounding. Depends on usvg_pkg.
module usvg_cordic import usvg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  input  logic [TexW-1:0]         phase_i,
  input  logic [TexW-1:0]         tag_i,
  output logic                    vld_o,
  output logic signed [NormW-1:0] cos_o,
  output logic signed [NormW-1:0] sin_o,
  output logic [TexW-1:0]         tag_o
);

  localparam int NS = CordicStages;

  function automatic logic signed [NormW-1:0] to_q14(input logic signed [XW-1:0] v,
                                                     input logic neg);
    logic signed [XW:0]    s;
    logic signed [XW-16:0] r;
    logic signed [NormW-1:0] c;
    s = $signed({v[XW-1], v}) + (XW+1)'(32768);
    r = s[XW:16];
    if (r > (XW-15)'(16384)) begin
      c = NormW'(16384);
    end else if (r < -(XW-15)'(16384)) begin
      c = -NormW'(16384);
    end else begin
      c = r[NormW-1:0];
    end
    return neg ? -c : c;
  endfunction

  logic [NS+2:0]   vld_q;
  logic [15:0]     m_q;
  logic            fnc_q, fns_q;
  logic [TexW-1:0] ftag_q;
  cordic_stage_t   c_q [NS+1];
  logic signed [NormW-1:0] cos_q, sin_q;
  logic [TexW-1:0] otag_q;

  logic            ns_d, nc_d;
  logic [TexW-1:0] ma_d, mb_d;
  logic [47:0]     zp_d;

  always_comb begin
    ns_d = phase_i > 17'd65536;
    ma_d = ns_d ? TexW'(18'd131072 - {1'b0, phase_i}) : phase_i;
    nc_d = ma_d > 17'd32768;
    mb_d = nc_d ? TexW'(17'd65536 - ma_d) : ma_d;
    zp_d = {32'd0, m_q} * {16'd0, PiQ30} + 48'd32768;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NS+1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    m_q        <= mb_d[15:0];
    fnc_q      <= nc_d;
    fns_q      <= ns_d;
    ftag_q     <= tag_i;
    c_q[0].x     <= GainQ30;
    c_q[0].y     <= '0;
    c_q[0].z     <= $signed({1'b0, zp_d[47:16]});
    c_q[0].neg_c <= fnc_q;
    c_q[0].neg_s <= fns_q;
    c_q[0].tag   <= ftag_q;
    cos_q      <= to_q14(c_q[NS].x, c_q[NS].neg_c);
    sin_q      <= to_q14(c_q[NS].y, c_q[NS].neg_s);
    otag_q     <= c_q[NS].tag;
  end

  for (genvar k = 0; k < NS; k++) begin : g_iter
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] a;
    assign dx = $signed(c_q[k].y) >>> k;
    assign dy = $signed(c_q[k].x) >>> k;
    assign a  = atan_q30(KW'(k));
    always_ff @(posedge clk_i) begin
      c_q[k+1].neg_c <= c_q[k].neg_c;
      c_q[k+1].neg_s <= c_q[k].neg_s;
      c_q[k+1].tag   <= c_q[k].tag;
      if (!c_q[k].z[ZW-1]) begin
        c_q[k+1].x <= $signed(c_q[k].x) - dx;
        c_q[k+1].y <= $signed(c_q[k].y) + dy;
        c_q[k+1].z <= $signed(c_q[k].z) - a;
      end else begin
        c_q[k+1].x <= $signed(c_q[k].x) + dx;
        c_q[k+1].y <= $signed(c_q[k].y) - dy;
        c_q[k+1].z <= $signed(c_q[k].z) + a;
      end
    end
  end

  assign vld_o = vld_q[NS+2];
  assign cos_o = cos_q;
  assign sin_o = sin_q;
  assign tag_o = otag_q;

endmodule

### hdl/uv_sphere_vertex_generator_unit.sv
// UV sphere vertex generator top level: config registers, index clamp,
// texcoord divider, two CORDICs, normal and position multipliers.
// Depends on usvg_pkg, usvg_div, usvg_cordic.
//
//  channel   | handshake            | payload
//  ----------+----------------------+--------------------------------------
//  request   | start_i / busy_o     | long_index_i, lat_index_i
//  result    | valid_o (strobe)     | pos_x/y/z_o, norm_x/y/z_o, tex_u/v_o
//  config    | cfg_we_i             | cfg_idx_i, cfg_wdata_i
//
// One beat enters per cycle; busy_o stays low. The pipeline has 18 divider stages,
// CordicStages + 3 CORDIC stages and 2 multiply stages (39 at 16 iterations).
// Reset clears config to 70/70/256 and empties the pipeline. Results cannot be
// held off.
module uv_sphere_vertex_generator_unit import usvg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [IdxW-1:0]         long_index_i,
  input  logic [IdxW-1:0]         lat_index_i,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgDataW-1:0]     cfg_wdata_i,
  output logic                    valid_o,
  output logic signed [PosW-1:0]  pos_x_o,
  output logic signed [PosW-1:0]  pos_y_o,
  output logic signed [PosW-1:0]  pos_z_o,
  output logic signed [NormW-1:0] norm_x_o,
  output logic signed [NormW-1:0] norm_y_o,
  output logic signed [NormW-1:0] norm_z_o,
  output logic [TexW-1:0]         tex_u_o,
  output logic [TexW-1:0]         tex_v_o
);

  logic [SegW-1:0] long_segs_q, lat_segs_q;
  logic [RadW-1:0] radius_q;

  logic [SegW-1:0] ls_d, ts_d, i_d, j_d;
  div_lane_t       lane_u_d, lane_v_d;

  logic            div_vld;
  logic [TexW-1:0] u_w, v_w;
  logic            th_vld, ph_vld;
  logic signed [NormW-1:0] ct_w, st_w, cp_w, sp_w;
  logic [TexW-1:0] th_tag, ph_tag;

  logic            n_vld_q, o_vld_q;
  logic signed [NormW-1:0] nx_q, ny_q, nz_q;
  logic [TexW-1:0] nu_q, nv_q;
  logic signed [31:0] px_d, pz_d;
  logic signed [PosW-1:0] posx_q, posy_q, posz_q;
  logic signed [NormW-1:0] onx_q, ony_q, onz_q;
  logic [TexW-1:0] ou_q, ov_q;
  logic signed [PosW-1:0] rs_d;
  logic signed [33:0] qx_d, qy_d, qz_d;

  function automatic logic [SegW-1:0] clamp_segs(input logic [SegW-1:0] n);
    logic [SegW-1:0] r;
    r = (n == '0) ? SegW'(1) : n;
    if (r > SegW'(MaxSegments)) begin
      r = SegW'(MaxSegments);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_segs_q <= SegW'(70);
      lat_segs_q  <= SegW'(70);
      radius_q    <= RadW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LONG_SEGS: long_segs_q <= cfg_wdata_i[SegW-1:0];
        CFG_LAT_SEGS:  lat_segs_q  <= cfg_wdata_i[SegW-1:0];
        CFG_RADIUS:    radius_q    <= cfg_wdata_i[RadW-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  always_comb begin
    ls_d = clamp_segs(long_segs_q);
    ts_d = clamp_segs(lat_segs_q);
    i_d  = (long_index_i > ls_d) ? ls_d : long_index_i;
    j_d  = (lat_index_i > ts_d) ? ts_d : lat_index_i;
    lane_u_d.rem = {1'b0, i_d[7:1]};
    lane_u_d.lo  = {i_d[0], 9'd0, ls_d[7:1]};
    lane_u_d.quo = '0;
    lane_u_d.dvs = ls_d;
    lane_v_d.rem = {1'b0, j_d[7:1]};
    lane_v_d.lo  = {j_d[0], 9'd0, ts_d[7:1]};
    lane_v_d.quo = '0;
    lane_v_d.dvs = ts_d;
  end

  usvg_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (start_i && !busy_o),
    .lane_u_i (lane_u_d),
    .lane_v_i (lane_v_d),
    .vld_o    (div_vld),
    .quo_u_o  (u_w),
    .quo_v_o  (v_w)
  );

  usvg_cordic u_cordic_theta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (div_vld),
    .phase_i ({u_w[TexW-2:0], 1'b0}),
    .tag_i   (u_w),
    .vld_o   (th_vld),
    .cos_o   (ct_w),
    .sin_o   (st_w),
    .tag_o   (th_tag)
  );

  usvg_cordic u_cordic_phi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (div_vld),
    .phase_i (v_w),
    .tag_i   (v_w),
    .vld_o   (ph_vld),
    .cos_o   (cp_w),
    .sin_o   (sp_w),
    .tag_o   (ph_tag)
  );

  always_comb begin
    px_d = ct_w * sp_w + 32'sd8192;
    pz_d = st_w * sp_w + 32'sd8192;
    rs_d = $signed({1'b0, radius_q});
    qx_d = 34'(nx_q * rs_d) + 34'sd8192;
    qy_d = 34'(ny_q * rs_d) + 34'sd8192;
    qz_d = 34'(nz_q * rs_d) + 34'sd8192;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      n_vld_q <= th_vld && ph_vld;
      o_vld_q <= n_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q   <= px_d[29:14];
    ny_q   <= cp_w;
    nz_q   <= pz_d[29:14];
    nu_q   <= th_tag;
    nv_q   <= ph_tag;
    posx_q <= qx_d[30:14];
    posy_q <= qy_d[30:14];
    posz_q <= qz_d[30:14];
    onx_q  <= nx_q;
    ony_q  <= ny_q;
    onz_q  <= nz_q;
    ou_q   <= nu_q;
    ov_q   <= nv_q;
  end

  assign valid_o  = o_vld_q;
  assign pos_x_o  = posx_q;
  assign pos_y_o  = posy_q;
  assign pos_z_o  = posz_q;
  assign norm_x_o = onx_q;
  assign norm_y_o = ony_q;
  assign norm_z_o = onz_q;
  assign tex_u_o  = ou_q;
  assign tex_v_o  = ov_q;

endmodule
